FILE: sv/twc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// twc_pkg
// Shared types and constants for the textured wall column stepper.
// ----------------------------------------------------------------------------
package twc_pkg;

    // shared multiplier operand and product widths
    localparam int MUL_W  = 28;
    localparam int PROD_W = 2 * MUL_W;

    // step quotient: dividend is at most 2^(10+16)
    localparam int HL_MAX   = 10;
    localparam int FRAC_W   = 16;
    localparam int Q_W      = HL_MAX + FRAC_W + 1;
    localparam int QCNT_W   = 5;
    localparam int DIVISOR_W = 16;

    // configuration register indexes
    localparam logic [1:0] CFG_TEX_WIDTH  = 2'd0;
    localparam logic [1:0] CFG_TEX_HL2    = 2'd1;
    localparam logic [1:0] CFG_ROW_BYTES  = 2'd2;
    localparam logic [1:0] CFG_PIX_BYTES  = 2'd3;

    // request kinds
    localparam logic KIND_LOAD = 1'b0;
    localparam logic KIND_STEP = 1'b1;

    typedef enum logic [9:0] {
        S_IDLE = 10'b00_0000_0001,
        S_HIT  = 10'b00_0000_0010,
        S_FRAC = 10'b00_0000_0100,
        S_TX   = 10'b00_0000_1000,
        S_MIR  = 10'b00_0001_0000,
        S_DIVW = 10'b00_0010_0000,
        S_POS  = 10'b00_0100_0000,
        S_POSW = 10'b00_1000_0000,
        S_STEP = 10'b01_0000_0000,
        S_EMIT = 10'b10_0000_0000
    } state_t;

    // divider launch request
    typedef struct packed {
        logic                 start;
        logic [QCNT_W-1:0]    shift;
        logic [DIVISOR_W-1:0] divisor;
    } div_req_t;

    // divider status
    typedef struct packed {
        logic           busy;
        logic [Q_W-1:0] quotient;
    } div_stat_t;

endpackage
`default_nettype wire

FILE: sv/twc_mul.sv
`default_nettype none
// ----------------------------------------------------------------------------
// twc_mul
// Shared signed multiplier with a registered product.
// ----------------------------------------------------------------------------
module twc_mul (
    input  wire logic                              clk,
    input  wire logic signed [twc_pkg::MUL_W-1:0]  op_a,
    input  wire logic signed [twc_pkg::MUL_W-1:0]  op_b,
    output logic signed [twc_pkg::PROD_W-1:0]      prod
);
    import twc_pkg::*;

    logic signed [PROD_W-1:0] prod_reg;

    always_ff @(posedge clk)
    begin
        prod_reg <= op_a * op_b;
    end

    assign prod = prod_reg;

endmodule
`default_nettype wire

FILE: sv/twc_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// twc_div
// Bit-serial restoring divider for the texture step, 2^shift / divisor,
// one quotient bit per cycle.
// ----------------------------------------------------------------------------
module twc_div (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire twc_pkg::div_req_t   req,
    output twc_pkg::div_stat_t       stat
);
    import twc_pkg::*;

    logic                 busy_reg,  busy_next;
    logic [QCNT_W-1:0]    idx_reg,   idx_next;
    logic [DIVISOR_W-1:0] rem_reg,   rem_next;
    logic [Q_W-1:0]       quo_reg,   quo_next;
    logic [DIVISOR_W-1:0] dvs_reg,   dvs_next;
    logic [QCNT_W-1:0]    shift_reg, shift_next;
    logic [DIVISOR_W:0]   trial;
    logic                 dbit;
    logic                 qbit;

    always_comb
    begin
        busy_next  = busy_reg;
        idx_next   = idx_reg;
        rem_next   = rem_reg;
        quo_next   = quo_reg;
        dvs_next   = dvs_reg;
        shift_next = shift_reg;
        // the dividend is a single one at bit position shift
        dbit  = (idx_reg == shift_reg);
        trial = {rem_reg, dbit};
        qbit  = (trial >= {1'b0, dvs_reg});
        if (req.start)
        begin
            busy_next  = 1'b1;
            idx_next   = QCNT_W'(Q_W - 1);
            rem_next   = '0;
            quo_next   = '0;
            dvs_next   = (req.divisor == '0) ? DIVISOR_W'(1) : req.divisor;
            shift_next = req.shift;
        end
        else if (busy_reg)
        begin
            rem_next = qbit ? DIVISOR_W'(trial - {1'b0, dvs_reg}) : trial[DIVISOR_W-1:0];
            quo_next = {quo_reg[Q_W-2:0], qbit};
            idx_next = idx_reg - QCNT_W'(1);
            if (idx_reg == '0)
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            idx_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            idx_reg  <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg   <= rem_next;
        quo_reg   <= quo_next;
        dvs_reg   <= dvs_next;
        shift_reg <= shift_next;
    end

    assign stat.busy     = busy_reg;
    assign stat.quotient = quo_reg;

endmodule
`default_nettype wire

FILE: sv/textured_wall_column.sv
`default_nettype none
// ----------------------------------------------------------------------------
// textured_wall_column
// Raycaster wall texturing: loads one screen column's ray data, works out
// texture column, step and start position, then emits one texel per step.
// ----------------------------------------------------------------------------
//  channel   signals                               role
//  item      item_valid/item_ready + fields        load or step request in
//  pix       pix_valid/pix_ready + fields          texel request out
//  cfg       cfg_valid/cfg_ready, cfg_index/data   register write
//
//  a load holds the block through the serial step divider (27 quotient bits,
//  one per cycle from accept) and the start position pass after it
//  a step goes through accept with the column offset in the multiplier,
//  one multiplier pass for the row offset, then emit
//  an empty step or a step with no column loaded is accepted in idle and emits no texel
//  a stalled pix channel holds the block in emit until the texel already on it is taken
//  reset is asynchronous, active low; registers return to 64, 6, 256, 4
// ----------------------------------------------------------------------------
module textured_wall_column #(
    parameter int SCREEN_HEIGHT = 1024
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    // request channel
    input  wire logic               item_valid,
    output logic                    item_ready,
    input  wire logic               kind,
    input  wire logic               hit_side,
    input  wire logic signed [19:0] ray_dir_x,
    input  wire logic signed [19:0] ray_dir_y,
    input  wire logic [23:0]        pos_x,
    input  wire logic [23:0]        pos_y,
    input  wire logic [23:0]        perp_dist,
    input  wire logic [15:0]        wall_height,
    input  wire logic [11:0]        draw_start,
    input  wire logic [11:0]        draw_end,
    input  wire logic [2:0]         tex_id,
    input  wire logic [11:0]        column,
    // texel channel
    output logic                    pix_valid,
    input  wire logic               pix_ready,
    output logic [11:0]             out_column,
    output logic [11:0]             screen_row,
    output logic [2:0]              out_texture,
    output logic [9:0]              texel_x,
    output logic [9:0]              texel_y,
    output logic [23:0]             texel_offset,
    output logic                    last,
    // configuration channel
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [1:0]         cfg_index,
    input  wire logic [13:0]        cfg_data
);
    import twc_pkg::*;

    localparam logic signed [17:0] HALF_H = 18'(SCREEN_HEIGHT / 2);

    // configuration
    logic [10:0] tex_width_reg;
    logic [3:0]  thl_reg;
    logic [13:0] row_bytes_reg;
    logic [3:0]  pix_bytes_reg;

    state_t state_reg, state_next;
    logic   active_reg, active_next;
    logic   pix_valid_reg, pix_valid_next;

    // column state
    logic [11:0]        cur_row_reg;
    logic [11:0]        end_row_reg;
    logic [47:0]        tex_pos_reg;
    logic [Q_W-1:0]     step_reg;
    logic [9:0]         held_tx_reg;
    logic [11:0]        held_col_reg;
    logic [2:0]         held_tex_reg;
    logic [13:0]        txb_reg;

    // load operands
    logic signed [19:0] ray_sel_reg;
    logic [15:0]        pos_lo_reg;
    logic [23:0]        dist_reg;
    logic               mirror_reg;
    logic signed [17:0] k_reg;
    logic [15:0]        frac_reg;
    logic [9:0]         ty_reg;

    // output payload
    logic [11:0] o_col_reg;
    logic [11:0] o_row_reg;
    logic [2:0]  o_tex_reg;
    logic [9:0]  o_tx_reg;
    logic [9:0]  o_ty_reg;
    logic [23:0] o_off_reg;
    logic        o_last_reg;

    logic                     item_acc;
    logic                     cfg_acc;
    logic                     emit_go;
    logic [3:0]               hl;
    logic [9:0]               hmask;
    logic [47:0]              neg_pos;
    logic [9:0]               ty_raw;
    logic [9:0]               ty_calc;
    logic [10:0]              tx_raw;
    logic [10:0]              tx_mir;
    logic                     ry_pos;
    logic                     mirror_calc;
    logic signed [17:0]       k_calc;
    logic signed [MUL_W-1:0]  mul_a;
    logic signed [MUL_W-1:0]  mul_b;
    logic signed [PROD_W-1:0] prod;
    div_req_t                 div_req;
    div_stat_t                div_stat;

    assign item_ready = (state_reg == S_IDLE);
    assign cfg_ready  = (state_reg == S_IDLE);
    assign item_acc   = item_valid && item_ready;
    assign cfg_acc    = cfg_valid && cfg_ready;
    assign emit_go    = (state_reg == S_EMIT) && (!pix_valid_reg || pix_ready);

    assign hl    = (thl_reg > 4'(HL_MAX)) ? 4'(HL_MAX) : thl_reg;
    assign hmask = 10'((11'd1 << hl) - 11'd1);

    // texture row: integer part truncated toward zero, masked to height
    assign neg_pos = 48'd0 - tex_pos_reg;
    assign ty_raw  = tex_pos_reg[47] ? (10'd0 - neg_pos[25:16]) : tex_pos_reg[25:16];
    assign ty_calc = ty_raw & hmask;

    assign tx_raw = prod[26:16];
    assign tx_mir = tex_width_reg - tx_raw - 11'd1;

    assign ry_pos      = !ray_dir_y[19] && (ray_dir_y != '0);
    assign mirror_calc = hit_side ? ry_pos : ray_dir_x[19];
    assign k_calc      = $signed({6'd0, draw_start}) - HALF_H
                         + $signed({3'd0, wall_height[15:1]});

    assign div_req.start   = item_acc && (kind == KIND_LOAD);
    assign div_req.shift   = QCNT_W'(hl) + QCNT_W'(FRAC_W);
    assign div_req.divisor = wall_height;

    twc_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .stat  (div_stat)
    );

    // operand selection for the shared multiplier
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            S_IDLE:
            begin
                // column byte offset with the current texel size, ready for a step
                mul_a = {18'd0, held_tx_reg};
                mul_b = {24'd0, pix_bytes_reg};
            end
            S_HIT:
            begin
                mul_a = {4'd0, dist_reg};
                mul_b = {{(MUL_W-20){ray_sel_reg[19]}}, ray_sel_reg};
            end
            S_TX:
            begin
                mul_a = {12'd0, frac_reg};
                mul_b = {17'd0, tex_width_reg};
            end
            S_POS:
            begin
                mul_a = {{(MUL_W-18){k_reg[17]}}, k_reg};
                mul_b = {1'b0, div_stat.quotient};
            end
            S_STEP, S_EMIT:
            begin
                mul_a = {18'd0, ty_reg};
                mul_b = {14'd0, row_bytes_reg};
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    twc_mul u_mul (
        .clk  (clk),
        .op_a (mul_a),
        .op_b (mul_b),
        .prod (prod)
    );

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        active_next    = active_reg;
        pix_valid_next = pix_valid_reg && !pix_ready;
        case (state_reg)
            S_IDLE:
            begin
                if (item_acc)
                begin
                    if (kind == KIND_LOAD)
                    begin
                        state_next  = S_HIT;
                        active_next = (draw_start < draw_end);
                    end
                    else if (active_reg && (cur_row_reg < end_row_reg))
                    begin
                        state_next = S_STEP;
                    end
                    else
                    begin
                        active_next = 1'b0;
                    end
                end
            end
            S_HIT:  state_next = S_FRAC;
            S_FRAC: state_next = S_TX;
            S_TX:   state_next = S_MIR;
            S_MIR:  state_next = S_DIVW;
            S_DIVW:
            begin
                if (!div_stat.busy)
                begin
                    state_next = S_POS;
                end
            end
            S_POS:  state_next = S_POSW;
            S_POSW: state_next = S_IDLE;
            S_STEP: state_next = S_EMIT;
            S_EMIT:
            begin
                if (emit_go)
                begin
                    state_next     = S_IDLE;
                    pix_valid_next = 1'b1;
                    active_next    = ({1'b0, cur_row_reg} + 13'd1) < {1'b0, end_row_reg};
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            active_reg    <= 1'b0;
            pix_valid_reg <= 1'b0;
            tex_width_reg <= 11'd64;
            thl_reg       <= 4'd6;
            row_bytes_reg <= 14'd256;
            pix_bytes_reg <= 4'd4;
        end
        else
        begin
            state_reg     <= state_next;
            active_reg    <= active_next;
            pix_valid_reg <= pix_valid_next;
            if (cfg_acc)
            begin
                case (cfg_index)
                    CFG_TEX_WIDTH: tex_width_reg <= cfg_data[10:0];
                    CFG_TEX_HL2:   thl_reg       <= cfg_data[3:0];
                    CFG_ROW_BYTES: row_bytes_reg <= cfg_data;
                    CFG_PIX_BYTES: pix_bytes_reg <= cfg_data[3:0];
                    default:       tex_width_reg <= tex_width_reg;
                endcase
            end
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (item_acc && (kind == KIND_LOAD))
        begin
            ray_sel_reg  <= hit_side ? ray_dir_x : ray_dir_y;
            pos_lo_reg   <= hit_side ? pos_x[15:0] : pos_y[15:0];
            dist_reg     <= perp_dist;
            mirror_reg   <= mirror_calc;
            k_reg        <= k_calc;
            cur_row_reg  <= draw_start;
            end_row_reg  <= draw_end;
            held_col_reg <= column;
            held_tex_reg <= tex_id;
        end
        if (item_acc && (kind == KIND_STEP))
        begin
            ty_reg <= ty_calc;
        end
        if (state_reg == S_FRAC)
        begin
            // fraction of the wall hit: bits 31..16 of (pos << 16) + dist * ray
            frac_reg <= pos_lo_reg + prod[31:16];
        end
        if (state_reg == S_MIR)
        begin
            held_tx_reg <= mirror_reg ? tx_mir[9:0] : tx_raw[9:0];
        end
        if (state_reg == S_STEP)
        begin
            txb_reg <= prod[13:0];
        end
        if (state_reg == S_POS)
        begin
            step_reg <= div_stat.quotient;
        end
        if (state_reg == S_POSW)
        begin
            tex_pos_reg <= prod[47:0];
        end
        if (emit_go)
        begin
            o_col_reg   <= held_col_reg;
            o_row_reg   <= cur_row_reg;
            o_tex_reg   <= held_tex_reg;
            o_tx_reg    <= held_tx_reg;
            o_ty_reg    <= ty_reg;
            o_off_reg   <= prod[23:0] + {10'd0, txb_reg};
            o_last_reg  <= ({1'b0, cur_row_reg} + 13'd1) >= {1'b0, end_row_reg};
            tex_pos_reg <= tex_pos_reg + {{(48-Q_W){1'b0}}, step_reg};
            cur_row_reg <= cur_row_reg + 12'd1;
        end
    end

    assign pix_valid    = pix_valid_reg;
    assign out_column   = o_col_reg;
    assign screen_row   = o_row_reg;
    assign out_texture  = o_tex_reg;
    assign texel_x      = o_tx_reg;
    assign texel_y      = o_ty_reg;
    assign texel_offset = o_off_reg;
    assign last         = o_last_reg;

    // the start position needs a finished step quotient
    a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_POS) |-> !div_stat.busy)
        else $error("start position taken before the step division finished");

    // a live column always has rows left
    a_active_rows: assert property (@(posedge clk) disable iff (!rst_n)
        active_reg |-> (cur_row_reg < end_row_reg))
        else $error("column marked active with no rows left");

    // an emitted texel shows up on the texel channel
    a_emit_shown: assert property (@(posedge clk) disable iff (!rst_n)
        emit_go |=> pix_valid)
        else $error("texel emitted but not presented");

endmodule
`default_nettype wire

FILE: tb/sv/textured_wall_column_test.sv
// ----------------------------------------------------------------------------
// textured_wall_column_test
// Self-checking bench for the wall column stepper. Column loads and pixel
// step requests come from a queue, a shadow model predicts every texel, and
// a monitor checks each emitted texel field by field, under several texture
// settings, random idling on both channels and one long output stall.
// ----------------------------------------------------------------------------
module textured_wall_column_test;
    import twc_pkg::*;

    localparam int SCREEN_ROWS    = 1024;
    localparam int SETTLE_CYCLES  = 64;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int LONG_HOLD      = 400;
    localparam int PHASES         = 8;
    localparam int PHASE_QUOTA    = 225;

    typedef struct packed {
        logic        kind;
        logic        hit_side;
        logic [19:0] ray_dir_x;
        logic [19:0] ray_dir_y;
        logic [23:0] pos_x;
        logic [23:0] pos_y;
        logic [23:0] perp_dist;
        logic [15:0] wall_height;
        logic [11:0] draw_start;
        logic [11:0] draw_end;
        logic [2:0]  tex_id;
        logic [11:0] column;
    } item_t;

    typedef struct packed {
        logic [11:0] col;
        logic [11:0] row;
        logic [2:0]  tex;
        logic [9:0]  tx;
        logic [9:0]  ty;
        logic [23:0] offset;
        logic        last;
    } texel_t;

    logic        clk        = 1'b0;
    logic        rst_n      = 1'b0;
    logic        item_valid = 1'b0;
    logic        item_ready;
    item_t       cur_item   = '0;
    logic        pix_valid;
    logic        pix_ready  = 1'b0;
    logic [11:0] out_column;
    logic [11:0] screen_row;
    logic [2:0]  out_texture;
    logic [9:0]  texel_x;
    logic [9:0]  texel_y;
    logic [23:0] texel_offset;
    logic        last;
    logic        cfg_valid  = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index  = CFG_TEX_WIDTH;
    logic [13:0] cfg_data   = '0;

    // shadow copy of registers and column state
    logic [10:0] tex_width     = 11'd64;
    logic [3:0]  tex_hl2       = 4'd6;
    logic [13:0] tex_row_bytes = 14'd256;
    logic [3:0]  tex_pix_bytes = 4'd4;
    logic        col_active    = 1'b0;
    logic [11:0] cur_row       = '0;
    logic [11:0] end_row       = '0;
    logic [47:0] tex_pos       = '0;
    logic [31:0] tex_step      = '0;
    logic [9:0]  held_tx       = '0;
    logic [11:0] held_col      = '0;
    logic [2:0]  held_tex      = '0;

    item_t  pending_requests[$];
    texel_t texel_expected[$];
    int     requests_owed = 0;
    int     send_gap      = 0;
    int     stall_left    = 0;
    int     hold_left     = 0;
    bit     hold_done     = 1'b0;
    bit     calm          = 1'b0;
    int     errors        = 0;
    int     texels_seen   = 0;
    int     loads_done    = 0;
    int     steps_done    = 0;
    int     reg_writes    = 0;
    int     quiet_cycles  = 0;

    textured_wall_column #(
        .SCREEN_HEIGHT(SCREEN_ROWS)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .item_valid    (item_valid),
        .item_ready    (item_ready),
        .kind          (cur_item.kind),
        .hit_side      (cur_item.hit_side),
        .ray_dir_x     (cur_item.ray_dir_x),
        .ray_dir_y     (cur_item.ray_dir_y),
        .pos_x         (cur_item.pos_x),
        .pos_y         (cur_item.pos_y),
        .perp_dist     (cur_item.perp_dist),
        .wall_height   (cur_item.wall_height),
        .draw_start    (cur_item.draw_start),
        .draw_end      (cur_item.draw_end),
        .tex_id        (cur_item.tex_id),
        .column        (cur_item.column),
        .pix_valid     (pix_valid),
        .pix_ready     (pix_ready),
        .out_column    (out_column),
        .screen_row    (screen_row),
        .out_texture   (out_texture),
        .texel_x       (texel_x),
        .texel_y       (texel_y),
        .texel_offset  (texel_offset),
        .last          (last),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #2 clk = ~clk;

    // shadow model: updates column state and queues the texel a request causes
    task automatic predict_texel(input item_t it);
        longint      ray_dist;
        longint      rdir;
        longint      hit;
        longint      tx;
        longint      kk;
        longint      prod;
        logic [15:0] frac;
        logic [15:0] wh;
        logic [63:0] dividend;
        logic [47:0] pos_mag;
        logic [10:0] hmask;
        logic [9:0]  ty;
        logic [31:0] offs;
        int unsigned hl;
        texel_t      t;
        hl = (tex_hl2 > HL_MAX) ? HL_MAX : tex_hl2;
        if (it.kind == KIND_LOAD) begin
            wh       = (it.wall_height == 16'd0) ? 16'd1 : it.wall_height;
            ray_dist = longint'(it.perp_dist);
            if (it.hit_side == 1'b0) begin
                rdir = longint'($signed(it.ray_dir_y));
                hit  = (longint'(it.pos_y) << 16) + ray_dist * rdir;
            end
            else begin
                rdir = longint'($signed(it.ray_dir_x));
                hit  = (longint'(it.pos_x) << 16) + ray_dist * rdir;
            end
            frac = hit[31:16];
            tx   = (longint'(frac) * longint'(tex_width)) >>> 16;
            // west-facing on x side, south-facing on y side
            if ((it.hit_side == 1'b0 && it.ray_dir_x[19]) ||
                (it.hit_side == 1'b1 && !it.ray_dir_y[19] && it.ray_dir_y != 20'd0))
                tx = longint'(tex_width) - tx - 1;
            dividend = 64'd1 << (hl + 16);
            tex_step = 32'(dividend / {48'd0, wh});
            kk       = longint'(it.draw_start) - longint'(SCREEN_ROWS / 2)
                       + longint'(wh >> 1);
            prod     = kk * longint'(tex_step);
            tex_pos  = prod[47:0];
            held_tx  = tx[9:0];
            held_col = it.column;
            held_tex = it.tex_id;
            cur_row  = it.draw_start;
            end_row  = it.draw_end;
            col_active = it.draw_start < it.draw_end;
        end
        else if (!col_active || cur_row >= end_row) begin
            col_active = 1'b0;
        end
        else begin
            hmask = (11'd1 << hl) - 11'd1;
            if (tex_pos[47]) begin
                // truncate toward zero for a negative position
                pos_mag = -tex_pos;
                pos_mag = pos_mag >> 16;
                ty = (10'd0 - pos_mag[9:0]) & hmask[9:0];
            end
            else begin
                ty = tex_pos[25:16] & hmask[9:0];
            end
            offs = 32'(ty) * 32'(tex_row_bytes) + 32'(held_tx) * 32'(tex_pix_bytes);
            t.col    = held_col;
            t.row    = cur_row;
            t.tex    = held_tex;
            t.tx     = held_tx;
            t.ty     = ty;
            t.offset = offs[23:0];
            t.last   = (int'(cur_row) + 1 >= int'(end_row));
            texel_expected.push_back(t);
            tex_pos = tex_pos + {16'd0, tex_step};
            cur_row = cur_row + 12'd1;
            if (cur_row >= end_row)
                col_active = 1'b0;
        end
    endtask

    function automatic item_t step_request();
        logic [191:0] raw;
        item_t        it;
        raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
        it = raw[$bits(item_t)-1:0];
        it.kind = KIND_STEP;
        return it;
    endfunction

    function automatic item_t column_load(input logic side, input logic [19:0] rx,
                                          input logic [19:0] ry, input logic [23:0] px,
                                          input logic [23:0] py, input logic [23:0] pdist,
                                          input logic [15:0] wh, input logic [11:0] ds,
                                          input logic [11:0] de, input logic [2:0] tex,
                                          input logic [11:0] col);
        item_t it;
        it = '{KIND_LOAD, side, rx, ry, px, py, pdist, wh, ds, de, tex, col};
        return it;
    endfunction

    task automatic offer(input item_t it);
        pending_requests.push_back(it);
        requests_owed++;
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [13:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            CFG_TEX_WIDTH: tex_width     = val[10:0];
            CFG_TEX_HL2:   tex_hl2       = val[3:0];
            CFG_ROW_BYTES: tex_row_bytes = val;
            CFG_PIX_BYTES: tex_pix_bytes = val[3:0];
            default:       ;
        endcase
        reg_writes++;
        cfg_valid <= 1'b0;
    endtask

    // wait for every request and texel, then let a load still in the divider finish
    task automatic wait_drained();
        while (requests_owed != 0 || texel_expected.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic queue_traffic(input int quota);
        int    counted;
        int    r;
        int    span;
        int    steps;
        item_t ld;
        counted = 0;
        while (counted < quota) begin
            r  = $urandom_range(0, 99);
            ld = step_request();
            ld.kind = KIND_LOAD;
            case ($urandom_range(0, 3))
                0:       ld.wall_height = 16'hFFFF;
                1:       ld.wall_height = 16'($urandom_range(1, 65535));
                default: ld.wall_height = 16'($urandom_range(1, 1500));
            endcase
            if ($urandom_range(0, 1) == 0)
                ld.perp_dist = 24'($urandom_range(0, 24'h0FFFFF));
            if (r < 80) begin
                span = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 120)
                                                   : $urandom_range(1, 24);
                if ($urandom_range(0, 2) == 0)
                    ld.draw_start = 12'($urandom_range(0, 4095 - span));
                else
                    ld.draw_start = 12'($urandom_range(0, 1023));
                ld.draw_end = 12'(int'(ld.draw_start) + span);
                // now and then cut the column short with the next load
                if ($urandom_range(0, 7) == 0)
                    steps = $urandom_range(0, span - 1);
                else
                    steps = span + (($urandom_range(0, 4) == 0) ? 1 : 0);
                offer(ld);
                counted += 1 + ((steps < span) ? steps : span);
            end
            else if (r < 90) begin
                ld.draw_end = 12'($urandom_range(0, ld.draw_start));
                steps = $urandom_range(0, 2);
                offer(ld);
                counted += 1;
            end
            else begin
                steps = $urandom_range(1, 3);
            end
            repeat (steps) offer(step_request());
        end
    endtask

    // request driver
    always @(posedge clk) begin : request_driver
        logic  nxt_valid;
        item_t nxt_item;
        if (rst_n) begin
            nxt_valid = item_valid;
            nxt_item  = cur_item;
            if (item_valid && item_ready) begin
                predict_texel(cur_item);
                if (cur_item.kind == KIND_LOAD)
                    loads_done++;
                else
                    steps_done++;
                requests_owed--;
                nxt_valid = 1'b0;
            end
            if (!nxt_valid) begin
                if (send_gap > 0) begin
                    send_gap--;
                end
                else if (pending_requests.size() > 0) begin
                    nxt_item  = pending_requests.pop_front();
                    nxt_valid = 1'b1;
                    if (!calm && $urandom_range(0, 11) == 0)
                        send_gap = $urandom_range(1, 10);
                end
            end
            item_valid <= nxt_valid;
            cur_item   <= nxt_item;
        end
    end

    // texel monitor and output back-pressure
    always @(posedge clk) begin : texel_monitor
        logic   nxt_ready;
        texel_t got;
        texel_t want;
        if (rst_n) begin
            if (pix_valid && pix_ready) begin
                got = {out_column, screen_row, out_texture, texel_x, texel_y,
                       texel_offset, last};
                texels_seen++;
                if (texel_expected.size() == 0) begin
                    errors++;
                    if (errors <= 10)
                        $display("unexpected texel: col %0d row %0d tex %0d x %0d y %0d",
                                 got.col, got.row, got.tex, got.tx, got.ty);
                end
                else begin
                    want = texel_expected.pop_front();
                    if (got !== want) begin
                        errors++;
                        if (errors <= 10)
                            $display({"texel mismatch: expected col %0d row %0d tex %0d ",
                                      "x %0d y %0d off %0h last %0d, got col %0d row %0d ",
                                      "tex %0d x %0d y %0d off %0h last %0d"},
                                     want.col, want.row, want.tex, want.tx, want.ty,
                                     want.offset, want.last, got.col, got.row, got.tex,
                                     got.tx, got.ty, got.offset, got.last);
                    end
                end
            end
            if (hold_left > 0) begin
                hold_left--;
                nxt_ready = 1'b0;
            end
            else if (!hold_done && texels_seen >= 80) begin
                // long stall so the block backs up onto the request side
                hold_done = 1'b1;
                hold_left = LONG_HOLD - 1;
                nxt_ready = 1'b0;
            end
            else if (stall_left > 0) begin
                stall_left--;
                nxt_ready = 1'b0;
            end
            else if (!calm && $urandom_range(0, 9) == 0) begin
                stall_left = $urandom_range(1, 10) - 1;
                nxt_ready  = 1'b0;
            end
            else begin
                nxt_ready = 1'b1;
            end
            pix_ready <= nxt_ready;
        end
    end

    always @(posedge clk) begin : watchdog
        if (rst_n) begin
            if ((item_valid && item_ready) || (pix_valid && pix_ready) ||
                (cfg_valid && cfg_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("watchdog: nothing accepted for %0d cycles", quiet_cycles);
                $display("Some tests failed");
                $finish;
            end
        end
    end

    initial begin : sequencer
        int unsigned tw_set[PHASES];
        int unsigned hl_set[PHASES];
        int unsigned rb_set[PHASES];
        int unsigned pb_set[PHASES];
        // minimum, maximum, zero width with saturated height, oversized width
        tw_set = '{1, 1024, 0, 2047, 0, 0, 0, 64};
        hl_set = '{0, 10, 15, 11, 0, 0, 0, 6};
        rb_set = '{1, 8192, 16383, 0, 0, 0, 0, 256};
        pb_set = '{1, 8, 15, 0, 0, 0, 0, 4};
        rb_set[3] = $urandom_range(1, 16383);
        pb_set[3] = $urandom_range(1, 15);
        for (int p = 4; p < 7; p++) begin
            tw_set[p] = $urandom_range(1, 1024);
            hl_set[p] = $urandom_range(0, 10);
            rb_set[p] = $urandom_range(1, 8192);
            pb_set[p] = $urandom_range(1, 8);
        end

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // directed column cases at reset settings
        offer(step_request());
        offer(column_load(1'b0, 20'h00001, 20'h00001, 24'd0, 24'd0, 24'd0, 16'd10,
                          12'd100, 12'd100, 3'd1, 12'd5));
        offer(step_request());
        offer(column_load(1'b1, 20'h00001, 20'h00001, 24'd0, 24'd0, 24'd0, 16'd10,
                          12'd200, 12'd100, 3'd2, 12'd6));
        offer(step_request());
        // zero wall height, west-facing mirror, extreme ray and position
        offer(column_load(1'b0, 20'h80000, 20'h7FFFF, 24'd0, 24'hFFFFFF, 24'hFFFFFF,
                          16'd0, 12'd0, 12'd2, 3'd7, 12'd4095));
        repeat (3) offer(step_request());
        // south-facing mirror, tallest wall, bottom rows
        offer(column_load(1'b1, 20'h7FFFF, 20'h00001, 24'hFFFFFF, 24'd0, 24'd0,
                          16'hFFFF, 12'd4093, 12'd4095, 3'd0, 12'd0));
        repeat (2) offer(step_request());
        // y side with zero ray y: no mirror, single pixel column
        offer(column_load(1'b1, 20'hFFFFF, 20'h00000, 24'd12345, 24'd0, 24'h008000,
                          16'd1, 12'd4094, 12'd4095, 3'd3, 12'd2048));
        offer(step_request());
        // x side, zero ray x, negative start position
        offer(column_load(1'b0, 20'h00000, 20'h80000, 24'h123456, 24'h654321, 24'h000FFF,
                          16'd3, 12'd0, 12'd3, 3'd4, 12'd1));
        repeat (3) offer(step_request());
        // a column cut short by the next load
        offer(column_load(1'b0, 20'h12345, 20'hEDCBA, 24'h0A0000, 24'h050000, 24'h020000,
                          16'd700, 12'd10, 12'd20, 3'd5, 12'd77));
        offer(step_request());
        offer(column_load(1'b1, 20'h3FFFF, 20'hC0000, 24'h7FFFFF, 24'h800000, 24'h010000,
                          16'd40, 12'd500, 12'd502, 3'd6, 12'd1234));
        repeat (2) offer(step_request());
        wait_drained();

        for (int p = 0; p < PHASES; p++) begin
            if (p == PHASES - 1)
                calm = 1'b1;
            write_reg(CFG_TEX_WIDTH, 14'(tw_set[p]));
            write_reg(CFG_TEX_HL2, 14'(hl_set[p]));
            write_reg(CFG_ROW_BYTES, 14'(rb_set[p]));
            write_reg(CFG_PIX_BYTES, 14'(pb_set[p]));
            queue_traffic(PHASE_QUOTA);
            wait_drained();
        end

        errors += texel_expected.size();
        $display("covered %0d column loads and %0d pixel steps, %0d texels checked",
                 loads_done, steps_done, texels_seen);
        $display("%0d register writes over %0d texture settings, one long output stall",
                 reg_writes, PHASES);
        if (errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
